// File: rtl/core/nine_point_stencil_apply_macros.svh
// Assertion macros for the stencil RTL, used by nps_line.
// Each macro expands to one labeled concurrent assertion on clk, disabled in rst.
`ifndef NINE_POINT_STENCIL_APPLY_MACROS_SVH
`define NINE_POINT_STENCIL_APPLY_MACROS_SVH

// The condition holds at every clock edge outside reset.
`define NPS_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// When the antecedent holds, the consequent holds at the next clock edge.
`define NPS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/nps_pkg.sv
// Shared types, widths and register codes for the 3x3 stencil block.
// Used by the channel interfaces and by every stencil module except the generic nps_ram.
`timescale 1ns / 1ps
`default_nettype none

package nps_pkg;

  // Field and storage widths
  localparam int SAMPLE_BITS  = 24;
  localparam int WEIGHT_BITS  = 18;
  localparam int WEIGHT_FRAC  = WEIGHT_BITS - 4;
  localparam int MAX_WIDTH    = 1024;
  localparam int HEIGHT_LIMIT = 1024;
  localparam int GEOM_BITS    = 11;
  localparam int COL_BITS     = $clog2(MAX_WIDTH);
  localparam int ROW_BITS     = GEOM_BITS;

  // Datapath widths: sum of four samples, product with a weight, final sum
  localparam int GSUM_BITS = SAMPLE_BITS + 2;
  localparam int PROD_BITS = WEIGHT_BITS + GSUM_BITS;
  localparam int ACC_BITS  = PROD_BITS + 2;

  // Configuration channel widths
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = WEIGHT_BITS;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [WEIGHT_BITS-1:0] weight_t;
  typedef logic [GEOM_BITS-1:0]          geom_t;

  localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam longint  ROUND_HALF = longint'(1) << (WEIGHT_FRAC - 1);

  // Reset values of the configuration registers
  localparam weight_t WC_RESET     = 18'sd65536;
  localparam weight_t WE_RESET     = -18'sd16384;
  localparam weight_t WD_RESET     = 18'sd0;
  localparam geom_t   WIDTH_RESET  = 11'd64;
  localparam geom_t   HEIGHT_RESET = 11'd64;

  // Register indexes on the configuration channel
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_WEIGHT_CENTER = 3'd0,
    REG_WEIGHT_EDGE   = 3'd1,
    REG_WEIGHT_DIAG   = 3'd2,
    REG_GRID_WIDTH    = 3'd3,
    REG_GRID_HEIGHT   = 3'd4
  } cfg_reg_t;

  // Current settings with geometry clamped to the supported range
  typedef struct packed {
    weight_t w_center;
    weight_t w_orth;
    weight_t w_diag;
    geom_t   width_eff;
    geom_t   height_eff;
  } cfg_regs_t;

  // Window request handed from the line stage to the arithmetic stages
  typedef struct packed {
    logic                        valid;
    logic                        last;
    logic [8:0][SAMPLE_BITS-1:0] win;
  } win_req_t;

endpackage

`default_nettype wire

// File: rtl/core/nps_if.sv
// Valid/ready channel interfaces for samples, results and configuration writes.
// Depends on nps_pkg for field types.
`timescale 1ns / 1ps
`default_nettype none

// Sample channel
interface nps_in_if import nps_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t sample;
  logic    flush;

  modport source (output valid, output sample, output flush, input ready);
  modport sink   (input valid, input sample, input flush, output ready);
endinterface

// Result channel
interface nps_out_if import nps_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t value;
  logic    last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

// Configuration write channel
interface nps_cfg_if import nps_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [CFG_INDEX_BITS-1:0] index;
  logic [CFG_DATA_BITS-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/core/nps_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module nps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/nps_cfg.sv
// Configuration registers of the stencil block and geometry clamping.
// Depends on nps_pkg and the nps_cfg_if interface.
`timescale 1ns / 1ps
`default_nettype none

module nps_cfg import nps_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  nps_cfg_if.sink   cfg,
  output cfg_regs_t regs,
  output logic      restart
);

  weight_t w_center;
  weight_t w_orth;
  weight_t w_diag;
  geom_t   grid_width;
  geom_t   grid_height;
  logic    cfg_fire;

  // Writes are always taken
  assign cfg.ready = 1'b1;
  assign cfg_fire  = cfg.valid && cfg.ready;

  // Register file; indexes beyond the list are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      w_center    <= WC_RESET;
      w_orth      <= WE_RESET;
      w_diag      <= WD_RESET;
      grid_width  <= WIDTH_RESET;
      grid_height <= HEIGHT_RESET;
    end else if (cfg_fire) begin
      case (cfg_reg_t'(cfg.index))
        REG_WEIGHT_CENTER: w_center    <= $signed(cfg.data[WEIGHT_BITS-1:0]);
        REG_WEIGHT_EDGE:   w_orth      <= $signed(cfg.data[WEIGHT_BITS-1:0]);
        REG_WEIGHT_DIAG:   w_diag      <= $signed(cfg.data[WEIGHT_BITS-1:0]);
        REG_GRID_WIDTH:    grid_width  <= cfg.data[GEOM_BITS-1:0];
        REG_GRID_HEIGHT:   grid_height <= cfg.data[GEOM_BITS-1:0];
        default: ;
      endcase
    end
  end

  // A geometry write abandons the grid in progress
  assign restart = cfg_fire &&
                   ((cfg_reg_t'(cfg.index) == REG_GRID_WIDTH) ||
                    (cfg_reg_t'(cfg.index) == REG_GRID_HEIGHT));

  // Clamp the geometry to the supported range
  always_comb begin
    regs.w_center = w_center;
    regs.w_orth   = w_orth;
    regs.w_diag   = w_diag;
    if (grid_width < GEOM_BITS'(3)) begin
      regs.width_eff = GEOM_BITS'(3);
    end else if (grid_width > GEOM_BITS'(MAX_WIDTH)) begin
      regs.width_eff = GEOM_BITS'(MAX_WIDTH);
    end else begin
      regs.width_eff = grid_width;
    end
    if (grid_height < GEOM_BITS'(3)) begin
      regs.height_eff = GEOM_BITS'(3);
    end else if (grid_height > GEOM_BITS'(HEIGHT_LIMIT)) begin
      regs.height_eff = GEOM_BITS'(HEIGHT_LIMIT);
    end else begin
      regs.height_eff = grid_height;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/nps_line.sv
// Raster position counters, the two line stores and the 3x3 sample window.
// Depends on nps_pkg, nps_in_if, nps_ram and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "nine_point_stencil_apply_macros.svh"

module nps_line import nps_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  nps_in_if.sink    samples,
  input  cfg_regs_t regs,
  input  logic      restart,
  input  logic      mac_ready,
  output win_req_t  win_out
);

  logic [COL_BITS-1:0]  col;
  logic [ROW_BITS-1:0]  row;
  logic [GEOM_BITS:0]   row_ext;
  logic [GEOM_BITS:0]   h_plus1;
  logic [GEOM_BITS-1:0] col_inc;
  logic                 accept;
  logic                 cur_emit;
  logic                 cur_last;
  logic                 cur_mid_ok;
  logic                 cur_top_ok;
  sample_t              cur_bot;

  // Stage one: item waiting for its line-store read data
  logic                 s1_valid;
  logic [COL_BITS-1:0]  s1_col;
  sample_t              s1_bot;
  logic                 s1_mid_ok;
  logic                 s1_top_ok;
  logic                 s1_col0;
  logic                 s1_emit;
  logic                 s1_last;
  logic                 s1_fire;
  logic                 s2_ld;

  logic [SAMPLE_BITS-1:0] mid_rd;
  logic [SAMPLE_BITS-1:0] top_rd;
  sample_t                new_col [3];
  sample_t                win      [9];
  sample_t                win_next [9];
  sample_t                cw       [9];
  win_req_t               s2;

  // Position decode of the item on the input channel
  assign row_ext = {1'b0, row};
  assign h_plus1 = {1'b0, regs.height_eff} + (GEOM_BITS + 1)'(1);
  assign col_inc = GEOM_BITS'(col) + GEOM_BITS'(1);

  always_comb begin
    cur_emit   = (row >= ROW_BITS'(2)) || ((row == ROW_BITS'(1)) && (col != '0));
    cur_last   = (row_ext == h_plus1) && (col == '0);
    cur_mid_ok = (row != '0) && (row <= regs.height_eff);
    cur_top_ok = (row >= ROW_BITS'(2)) && (row_ext <= h_plus1);
    if (samples.flush || (row >= regs.height_eff)) begin
      cur_bot = '0;
    end else begin
      cur_bot = samples.sample;
    end
  end

  // Handshake: stage one frees when the window stage can take its result
  assign s2_ld         = !s2.valid || mac_ready;
  assign s1_fire       = s1_valid && s2_ld;
  assign samples.ready = !s1_valid || s2_ld;
  assign accept        = samples.valid && samples.ready;

  // Raster position counters
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      if (cur_last) begin
        col <= '0;
        row <= '0;
      end else if (col_inc >= regs.width_eff) begin
        col <= '0;
        row <= row + ROW_BITS'(1);
      end else begin
        col <= col_inc[COL_BITS-1:0];
      end
    end
  end

  // Stage one register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_col    <= col;
      s1_bot    <= cur_bot;
      s1_mid_ok <= cur_mid_ok;
      s1_top_ok <= cur_top_ok;
      s1_col0   <= (col == '0);
      s1_emit   <= cur_emit;
      s1_last   <= cur_last;
    end
  end

  // Line stores: the middle row moves up, the new sample enters the middle row
  nps_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_WIDTH)
  ) u_mid_row (
    .clk   (clk),
    .we    (s1_fire),
    .waddr (s1_col),
    .wdata (s1_bot),
    .re    (accept),
    .raddr (col),
    .rdata (mid_rd)
  );

  nps_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_WIDTH)
  ) u_top_row (
    .clk   (clk),
    .we    (s1_fire),
    .waddr (s1_col),
    .wdata (mid_rd),
    .re    (accept),
    .raddr (col),
    .rdata (top_rd)
  );

  // New window column, with rows outside the grid masked to zero
  always_comb begin
    new_col[0] = s1_top_ok ? $signed(top_rd) : '0;
    new_col[1] = s1_mid_ok ? $signed(mid_rd) : '0;
    new_col[2] = s1_bot;
  end

  // Window shift. At the start of a row the output belongs to the last column
  // of the previous row, so its right column is outside the grid.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      cw[k*3+0]       = win[k*3+1];
      cw[k*3+1]       = win[k*3+2];
      cw[k*3+2]       = s1_col0 ? '0 : new_col[k];
      win_next[k*3+0] = s1_col0 ? '0 : win[k*3+1];
      win_next[k*3+1] = s1_col0 ? '0 : win[k*3+2];
      win_next[k*3+2] = new_col[k];
    end
    if (s1_last) begin
      for (int k = 0; k < 9; k++) begin
        win_next[k] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      for (int k = 0; k < 9; k++) begin
        win[k] <= '0;
      end
    end else if (s1_fire) begin
      for (int k = 0; k < 9; k++) begin
        win[k] <= win_next[k];
      end
    end
  end

  // Stage two: window of an item that produces a result
  always_ff @(posedge clk) begin
    if (rst) begin
      s2.valid <= 1'b0;
    end else if (s2_ld) begin
      s2.valid <= s1_valid && s1_emit;
    end
    if (s2_ld) begin
      s2.last <= s1_last;
      for (int k = 0; k < 9; k++) begin
        s2.win[k] <= cw[k];
      end
    end
  end

  assign win_out = s2;

  // Checks on position tracking and the stage-one hold
  `NPS_ASSERT_ALWAYS(a_col_in_grid, GEOM_BITS'(col) < regs.width_eff,
    "column counter outside the grid width")
  `NPS_ASSERT_ALWAYS(a_row_in_range, row_ext <= h_plus1,
    "row counter beyond the drain row")
  `NPS_ASSERT_NEXT(a_last_restarts, accept && cur_last, (row == '0) && (col == '0),
    "counters did not restart after the final output")
  `NPS_ASSERT_NEXT(a_s1_holds, s1_valid && !s2_ld, s1_valid,
    "stalled stage-one item was dropped")

endmodule

`default_nettype wire

// File: rtl/core/nps_mac.sv
// Weighted sum of the 3x3 window, rounding, saturation and the result register.
// Depends on nps_pkg and the nps_out_if interface.
`timescale 1ns / 1ps
`default_nettype none

module nps_mac import nps_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  win_req_t  win_in,
  output logic      win_ready,
  input  cfg_regs_t regs,
  nps_out_if.source results
);

  // Stage three: center sample and the two neighbor sums
  logic                        s3_valid;
  logic                        s3_last;
  logic signed [GSUM_BITS-1:0] s3_cen;
  logic signed [GSUM_BITS-1:0] s3_orth;
  logic signed [GSUM_BITS-1:0] s3_diag;
  logic                        s3_ld;

  // Stage four: the three weighted products
  logic                        s4_valid;
  logic                        s4_last;
  logic signed [PROD_BITS-1:0] s4_pc;
  logic signed [PROD_BITS-1:0] s4_po;
  logic signed [PROD_BITS-1:0] s4_pd;
  logic                        s4_ld;

  logic                        out_ld;
  logic signed [ACC_BITS-1:0]  acc;
  logic [ACC_BITS-SAMPLE_BITS-WEIGHT_FRAC:0] acc_hi;
  sample_t                     sat_value;

  // Back-pressure chain toward the window stage
  assign out_ld    = !results.valid || results.ready;
  assign s4_ld     = !s4_valid || out_ld;
  assign s3_ld     = !s3_valid || s4_ld;
  assign win_ready = s3_ld;

  // Pre-add the neighbors that share a weight
  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (s3_ld) begin
      s3_valid <= win_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_ld) begin
      s3_last <= win_in.last;
      s3_cen  <= GSUM_BITS'($signed(win_in.win[4]));
      s3_orth <= GSUM_BITS'($signed(win_in.win[1])) + GSUM_BITS'($signed(win_in.win[3]))
               + GSUM_BITS'($signed(win_in.win[5])) + GSUM_BITS'($signed(win_in.win[7]));
      s3_diag <= GSUM_BITS'($signed(win_in.win[0])) + GSUM_BITS'($signed(win_in.win[2]))
               + GSUM_BITS'($signed(win_in.win[6])) + GSUM_BITS'($signed(win_in.win[8]));
    end
  end

  // One multiplier per weight
  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (s4_ld) begin
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s4_ld) begin
      s4_last <= s3_last;
      s4_pc   <= PROD_BITS'(regs.w_center) * PROD_BITS'(s3_cen);
      s4_po   <= PROD_BITS'(regs.w_orth) * PROD_BITS'(s3_orth);
      s4_pd   <= PROD_BITS'(regs.w_diag) * PROD_BITS'(s3_diag);
    end
  end

  // Round half up, drop the weight fraction, saturate to the sample range
  always_comb begin
    acc = ACC_BITS'(s4_pc) + ACC_BITS'(s4_po) + ACC_BITS'(s4_pd) + ACC_BITS'(ROUND_HALF);
    acc_hi = acc[ACC_BITS-1:SAMPLE_BITS+WEIGHT_FRAC-1];
    if ((&acc_hi) || !(|acc_hi)) begin
      sat_value = acc[SAMPLE_BITS+WEIGHT_FRAC-1:WEIGHT_FRAC];
    end else if (acc[ACC_BITS-1]) begin
      sat_value = SAMPLE_MIN;
    end else begin
      sat_value = SAMPLE_MAX;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (out_ld) begin
      results.valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ld) begin
      results.value <= sat_value;
      results.last  <= s4_last;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/nine_point_stencil_apply.sv
// Streaming 3x3 symmetric stencil with a zero boundary.
// Samples enter on the samples channel in raster order, one request per
// grid position; results leave on the results channel in the same order.
// Weights and grid geometry are to be written on the cfg channel only while
// idle, which the block itself does not enforce; a geometry write restarts
// the grid. After the last sample of a grid, send grid_width + 1 requests with
// flush set to drain the final results; the final result of the grid carries last.
// The result for a position is produced by the request that arrives
// grid_width + 1 positions after it, and passes through stages one to four
// and the result register before it becomes valid on results.
// Throughput is one request per cycle while results do not stall: each
// request does one read and one write of the two line-store RAMs, and
// every stage is a single register. Reset restores the default weights and
// a 64 x 64 grid and clears the counters and window; the line stores are
// not cleared, as rows that were not yet written in the current grid are
// masked to zero. When the receiver stalls, the result register holds its
// request, the empty stages ahead of it keep filling, and samples.ready then drops.
`timescale 1ns / 1ps
`default_nettype none

module nine_point_stencil_apply import nps_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  nps_in_if.sink    samples,
  nps_out_if.source results,
  nps_cfg_if.sink   cfg
);

  cfg_regs_t regs;
  logic      restart;
  logic      mac_ready;
  win_req_t  win_req;

  // Configuration registers
  nps_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .regs    (regs),
    .restart (restart)
  );

  // Position tracking, line stores and window
  nps_line u_line (
    .clk       (clk),
    .rst       (rst),
    .samples   (samples),
    .regs      (regs),
    .restart   (restart),
    .mac_ready (mac_ready),
    .win_out   (win_req)
  );

  // Weighted sum and result register
  nps_mac u_mac (
    .clk       (clk),
    .rst       (rst),
    .win_in    (win_req),
    .win_ready (mac_ready),
    .regs      (regs),
    .results   (results)
  );

endmodule

`default_nettype wire

// File: test/tb_nine_point_stencil_apply.sv
// Self-checking testbench for nine_point_stencil_apply: streams raster grids through the
// samples channel and checks every result against a cycle-free 3x3 stencil predictor.
// Depends on nps_pkg, the channel interfaces in nps_if.sv and the stencil RTL.
`timescale 1ns / 1ps

module tb_nine_point_stencil_apply;
  import nps_pkg::*;

  localparam int     SETTLE_CYCLES = 16;
  localparam longint TIMEOUT_NS    = 64'd20_000_000;

  typedef struct {
    sample_t sample;
    logic    flush;
  } grid_item_t;

  typedef struct {
    sample_t value;
    logic    last;
  } stencil_out_t;

  logic clk;
  logic rst;

  nps_in_if  samples_if ();
  nps_out_if results_if ();
  nps_cfg_if cfg_if ();

  nine_point_stencil_apply u_top (
    .clk     (clk),
    .rst     (rst),
    .samples (samples_if),
    .results (results_if),
    .cfg     (cfg_if)
  );

  // Stimulus waiting to be sent and outputs waiting to arrive.
  grid_item_t   sample_queue[$];
  stencil_out_t pending_outputs[$];
  grid_item_t   next_item;
  stencil_out_t seen_output;

  int gap_pct;
  int stall_pct;
  int mismatch_count;

  // Predictor copy of the settings and of the streaming state.
  weight_t     w_center;
  weight_t     w_edge;
  weight_t     w_diag;
  geom_t       grid_w_reg;
  geom_t       grid_h_reg;
  longint      line_mem[2*MAX_WIDTH];
  longint      win[9];
  int unsigned col_pos;
  int unsigned row_pos;
  int unsigned emitted_cnt;

  always #10 clk = ~clk;

  function automatic int unsigned eff_width();
    if (grid_w_reg < 3) return 3;
    if (grid_w_reg > MAX_WIDTH) return MAX_WIDTH;
    return grid_w_reg;
  endfunction

  function automatic int unsigned eff_height();
    if (grid_h_reg < 3) return 3;
    if (grid_h_reg > HEIGHT_LIMIT) return HEIGHT_LIMIT;
    return grid_h_reg;
  endfunction

  function automatic void restart_grid_pos();
    foreach (win[k]) win[k] = 0;
    col_pos = 0;
    row_pos = 0;
    emitted_cnt = 0;
  endfunction

  // Mirror a register write into the predictor; geometry writes abandon the grid.
  function automatic void apply_setting(input logic [CFG_INDEX_BITS-1:0] idx,
                                        input logic [CFG_DATA_BITS-1:0] data);
    case (idx)
      REG_WEIGHT_CENTER: w_center = weight_t'(data);
      REG_WEIGHT_EDGE:   w_edge = weight_t'(data);
      REG_WEIGHT_DIAG:   w_diag = weight_t'(data);
      REG_GRID_WIDTH: begin
        grid_w_reg = data[GEOM_BITS-1:0];
        restart_grid_pos();
      end
      REG_GRID_HEIGHT: begin
        grid_h_reg = data[GEOM_BITS-1:0];
        restart_grid_pos();
      end
      default: ;
    endcase
  endfunction

  // Weighted window sum, rounded half up and saturated to the sample range.
  function automatic sample_t stencil_sum();
    longint acc;
    longint q;
    acc = longint'(w_center) * win[4]
        + longint'(w_edge) * (win[1] + win[3] + win[5] + win[7])
        + longint'(w_diag) * (win[0] + win[2] + win[6] + win[8]);
    q = (acc + ROUND_HALF) >>> WEIGHT_FRAC;
    if (q > longint'(SAMPLE_MAX)) q = longint'(SAMPLE_MAX);
    if (q < longint'(SAMPLE_MIN)) q = longint'(SAMPLE_MIN);
    return sample_t'(q);
  endfunction

  // Advance the stencil by one accepted request and queue the output it yields.
  function automatic void stencil_advance(input sample_t in_sample, input logic in_flush);
    int unsigned w;
    int unsigned h;
    int unsigned r;
    int unsigned c;
    longint      bot;
    longint      mid;
    longint      top;
    sample_t     result;
    bit          emit;
    bit          is_last;
    w = eff_width();
    h = eff_height();
    r = row_pos;
    c = (col_pos < w) ? col_pos : w - 1;
    emit = (r * w + c) >= w + 1;
    is_last = 1'b0;
    result = '0;
    bot = in_flush ? 0 : longint'(in_sample);
    mid = line_mem[c];
    top = line_mem[MAX_WIDTH + c];
    if (r >= h) bot = 0;
    if (r < 1 || r > h) mid = 0;
    if (r < 2 || r > h + 1) top = 0;
    line_mem[MAX_WIDTH + c] = line_mem[c];
    line_mem[c] = bot;

    // At the start of a row the pending output sits on the right border.
    for (int k = 0; k < 3; k++) begin
      win[k*3] = win[k*3 + 1];
      win[k*3 + 1] = win[k*3 + 2];
      if (c == 0) win[k*3 + 2] = 0;
    end
    if (c == 0) begin
      if (emit) result = stencil_sum();
      foreach (win[k]) win[k] = 0;
    end
    win[2] = top;
    win[5] = mid;
    win[8] = bot;
    if (c != 0 && emit) result = stencil_sum();

    if (emit) begin
      is_last = emitted_cnt >= w * h - 1;
      pending_outputs.push_back('{value: result, last: is_last});
      if (is_last) restart_grid_pos();
      else emitted_cnt++;
    end
    if (!is_last) begin
      if (c + 1 >= w) begin
        col_pos = 0;
        row_pos = r + 1;
      end else begin
        col_pos = c + 1;
      end
    end
  endfunction

  // Sample driver: holds each request until the block takes it.
  always @(posedge clk) begin
    if (rst) begin
      samples_if.valid <= 1'b0;
      samples_if.sample <= '0;
      samples_if.flush <= 1'b0;
    end else begin
      if (samples_if.valid && samples_if.ready)
        stencil_advance(samples_if.sample, samples_if.flush);
      if (!samples_if.valid || samples_if.ready) begin
        if (sample_queue.size() > 0 && $urandom_range(0, 99) >= gap_pct) begin
          next_item = sample_queue.pop_front();
          samples_if.valid <= 1'b1;
          samples_if.sample <= next_item.sample;
          samples_if.flush <= next_item.flush;
        end else begin
          samples_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compares each accepted result with the oldest prediction.
  always @(posedge clk) begin
    if (rst) begin
      results_if.ready <= 1'b0;
    end else begin
      if (results_if.valid && results_if.ready) begin
        if (pending_outputs.size() == 0) begin
          $error("unexpected result: value %0d last %0b", results_if.value, results_if.last);
          mismatch_count++;
        end else begin
          seen_output = pending_outputs.pop_front();
          if (results_if.value !== seen_output.value) begin
            $error("value: expected %0d, actual %0d", seen_output.value, results_if.value);
            mismatch_count++;
          end
          if (results_if.last !== seen_output.last) begin
            $error("last: expected %0b, actual %0b", seen_output.last, results_if.last);
            mismatch_count++;
          end
        end
      end
      results_if.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= data;
    do @(posedge clk); while (!cfg_if.ready);
    apply_setting(idx, data);
    cfg_if.valid <= 1'b0;
  endtask

  // Geometry write with random bits above the geometry field.
  task automatic write_geom(input logic [CFG_INDEX_BITS-1:0] idx, input int unsigned size);
    logic [CFG_DATA_BITS-1:0] data;
    data = CFG_DATA_BITS'($urandom);
    data[GEOM_BITS-1:0] = GEOM_BITS'(size);
    write_reg(idx, data);
  endtask

  // Wait until every request is sent and every prediction has been matched.
  task automatic wait_idle();
    while (sample_queue.size() != 0 || samples_if.valid || pending_outputs.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic sample_t random_sample();
    case ($urandom_range(0, 9))
      0: return SAMPLE_MAX;
      1: return SAMPLE_MIN;
      2: return sample_t'($urandom_range(0, 8191)) - sample_t'(4096);
      default: return sample_t'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_DATA_BITS-1:0] random_weight();
    case ($urandom_range(0, 7))
      0: return {1'b0, {(WEIGHT_BITS-1){1'b1}}};
      1: return {1'b1, {(WEIGHT_BITS-1){1'b0}}};
      2: return '0;
      3: return CFG_DATA_BITS'($urandom_range(0, 32768)) - CFG_DATA_BITS'(16384);
      default: return CFG_DATA_BITS'($urandom);
    endcase
  endfunction

  function automatic void push_item(input sample_t s, input logic f);
    sample_queue.push_back('{sample: s, flush: f});
  endfunction

  // Queue one grid plus its drain, or only its first cut requests when cut >= 0.
  // Mostly real samples inside the grid and flush requests in the drain.
  function automatic void queue_grid(input int cut);
    int unsigned w;
    int unsigned h;
    int unsigned total;
    w = eff_width();
    h = eff_height();
    total = w * h + w + 1;
    if (cut >= 0 && cut < total) total = cut;
    for (int unsigned n = 0; n < total; n++) begin
      if (n < w * h) push_item(random_sample(), $urandom_range(0, 19) == 0);
      else push_item(random_sample(), $urandom_range(0, 4) != 0);
    end
  endfunction

  // Random grids under one idling mode; geometry, weights and cuts vary per grid.
  task automatic random_phase(input int gap, input int stall, input int grids);
    bit grid_open;
    grid_open = 1'b0;
    gap_pct <= gap;
    stall_pct <= stall;
    for (int g = 0; g < grids; g++) begin
      wait_idle();
      if ($urandom_range(0, 1) == 1) write_reg(REG_WEIGHT_CENTER, random_weight());
      if ($urandom_range(0, 1) == 1) write_reg(REG_WEIGHT_EDGE, random_weight());
      if ($urandom_range(0, 1) == 1) write_reg(REG_WEIGHT_DIAG, random_weight());
      if ($urandom_range(0, 9) == 0)
        write_reg(CFG_INDEX_BITS'($urandom_range(int'(REG_GRID_HEIGHT) + 1,
                                                 (1 << CFG_INDEX_BITS) - 1)),
                  CFG_DATA_BITS'($urandom));
      if (grid_open || $urandom_range(0, 2) == 0)
        write_geom(REG_GRID_WIDTH, ($urandom_range(0, 5) == 0) ? $urandom_range(0, 2)
                                                               : $urandom_range(3, 8));
      if (grid_open || $urandom_range(0, 2) == 0)
        write_geom(REG_GRID_HEIGHT, ($urandom_range(0, 5) == 0) ? $urandom_range(0, 2)
                                                                : $urandom_range(3, 6));
      grid_open = ($urandom_range(0, 5) == 0);
      if (grid_open) begin
        queue_grid($urandom_range(1, eff_width() * eff_height() + eff_width()));
      end else begin
        queue_grid(-1);
        if ($urandom_range(0, 2) == 0) queue_grid(-1);
      end
    end
    // Leave no grid half done for the next phase.
    wait_idle();
    if (grid_open) write_geom(REG_GRID_HEIGHT, $urandom_range(3, 6));
  endtask

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    gap_pct = 0;
    stall_pct = 0;
    mismatch_count = 0;
    samples_if.valid = 1'b0;
    samples_if.sample = '0;
    samples_if.flush = 1'b0;
    results_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    w_center = WC_RESET;
    w_edge = WE_RESET;
    w_diag = WD_RESET;
    grid_w_reg = WIDTH_RESET;
    grid_h_reg = HEIGHT_RESET;
    foreach (line_mem[k]) line_mem[k] = 0;
    restart_grid_pos();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // The first 70 requests of a grid at the reset settings, then abandoned by the geometry write below.
    queue_grid(70);
    wait_idle();

    // Directed 3x3 grid: field extremes, a flush inside the grid, a sample in the drain.
    write_reg(REG_GRID_WIDTH, CFG_DATA_BITS'(3));
    write_reg(REG_GRID_HEIGHT, CFG_DATA_BITS'(3));
    push_item(SAMPLE_MAX, 1'b0);
    push_item(SAMPLE_MIN, 1'b0);
    push_item('0, 1'b0);
    push_item('1, 1'b0);
    push_item(sample_t'(1), 1'b0);
    push_item(SAMPLE_MAX, 1'b0);
    push_item(sample_t'(24'h5A5A5A), 1'b1);
    push_item(SAMPLE_MIN, 1'b0);
    push_item(sample_t'(24'h123456), 1'b0);
    push_item(sample_t'(24'hA5A5A5), 1'b1);
    push_item(SAMPLE_MAX, 1'b0);
    push_item('0, 1'b1);
    push_item(SAMPLE_MIN, 1'b1);
    wait_idle();

    // Extreme weights on a random grid with extreme samples mixed in, to drive the results into saturation.
    write_reg(REG_WEIGHT_CENTER, {1'b0, {(WEIGHT_BITS-1){1'b1}}});
    write_reg(REG_WEIGHT_EDGE, {1'b0, {(WEIGHT_BITS-1){1'b1}}});
    write_reg(REG_WEIGHT_DIAG, {1'b1, {(WEIGHT_BITS-1){1'b0}}});
    queue_grid(-1);

    random_phase(0, 0, 4);
    random_phase(66, 0, 4);
    random_phase(0, 66, 4);
    random_phase(30, 30, 4);

    // Geometry beyond the supported range is clamped; the grid is abandoned early.
    write_geom(REG_GRID_WIDTH, (1 << GEOM_BITS) - 1);
    write_geom(REG_GRID_HEIGHT, (1 << GEOM_BITS) - 1);
    queue_grid(40);
    wait_idle();

    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog against a stalled handshake or missing results.
  initial begin
    #(TIMEOUT_NS);
    $display("FAILED: results differ");
    $finish;
  end

endmodule
